>>> hdl/dtpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpq_pkg
// types and constants shared by the drop-tail packet queue
// ----------------------------------------------------------------------------
package dtpq_pkg;

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] CFG_LIMIT_MODE  = 2'd0;
	localparam logic [1:0] CFG_MAX_PACKETS = 2'd1;
	localparam logic [1:0] CFG_MAX_BYTES   = 2'd2;

	localparam logic        LIMIT_MODE_RST  = 1'b0;
	localparam logic [7:0]  MAX_PACKETS_RST = 8'd100;
	localparam logic [31:0] MAX_BYTES_RST   = 32'd6553500;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] pkt_handle;
		logic [15:0] pkt_size;
	} cmd_t;

	typedef struct packed {
		logic        accepted;
		logic        dropped;
		logic        found;
		logic [15:0] head_handle;
		logic [15:0] head_size;
		logic [7:0]  packet_count;
		logic [31:0] byte_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [15:0] size;
	} entry_t;

endpackage

>>> hdl/dtpq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtpq_store
// descriptor memory, one write port and one registered read port with
// write-to-read forwarding so the head entry is always ready
// ----------------------------------------------------------------------------
module dtpq_store
	import dtpq_pkg::*;
#(
	parameter int DEPTH = 128,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> hdl/drop_tail_packet_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drop_tail_packet_queue_core
// fifo of packet descriptors with drop-tail admission by packet or byte limit
// result registered after the command register; throughput one command a cycle
// busy stays low; the head entry is prefetched by the memory read port
// reset clears pointers and counts and restores default limits; memory not cleared
// ----------------------------------------------------------------------------
module drop_tail_packet_queue_core
	import dtpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output rsp_t        result
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	logic             limit_mode_q;
	logic [7:0]       max_packets_q;
	logic [31:0]      max_bytes_q;

	logic             valid_s1;
	cmd_t             cmd_s1;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      bytes_q;

	logic             valid_s2;
	rsp_t             rsp_s2;

	logic             is_enq;
	logic             is_look;
	logic             full;
	logic             refuse;
	logic             do_push;
	logic             do_pop;
	logic             found;
	logic [32:0]      byte_sum;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;
	logic [CNT_W-1:0] cnt_next;
	logic [31:0]      bytes_next;
	entry_t           wr_entry;
	entry_t           head_entry;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_mode_q  <= LIMIT_MODE_RST;
			max_packets_q <= MAX_PACKETS_RST;
			max_bytes_q   <= MAX_BYTES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LIMIT_MODE:  limit_mode_q  <= cfg_data[0];
				CFG_MAX_PACKETS: max_packets_q <= cfg_data[7:0];
				CFG_MAX_BYTES:   max_bytes_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= cmd;
		end
	end

	always_comb begin
		is_enq   = (cmd_s1.op == OP_ENQ);
		is_look  = (cmd_s1.op == OP_DEQ) || (cmd_s1.op == OP_PEEK);
		full     = (cnt_q >= CNT_W'(QUEUE_DEPTH));
		byte_sum = {1'b0, bytes_q} + 33'(cmd_s1.pkt_size);
		if (full) begin
			refuse = 1'b1;
		end else if (!limit_mode_q) begin
			refuse = (CMP_W'(cnt_q) >= CMP_W'(max_packets_q));
		end else begin
			refuse = (byte_sum >= {1'b0, max_bytes_q});
		end
		do_push = valid_s1 && is_enq && !refuse;
		found   = valid_s1 && is_look && (cnt_q != '0);
		do_pop  = found && (cmd_s1.op == OP_DEQ);

		head_next = head_q;
		if (do_pop) begin
			head_next = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		end
		tail_next = tail_q;
		if (do_push) begin
			tail_next = (tail_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
		end

		cnt_next   = cnt_q;
		bytes_next = bytes_q;
		if (do_push) begin
			cnt_next   = cnt_q + 1'b1;
			bytes_next = byte_sum[31:0];
		end else if (do_pop) begin
			cnt_next   = cnt_q - 1'b1;
			bytes_next = bytes_q - 32'(head_entry.size);
		end

		wr_entry.handle = cmd_s1.pkt_handle;
		wr_entry.size   = cmd_s1.pkt_size;
	end

	dtpq_store #(
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (tail_q),
		.wr_data (wr_entry),
		.rd_addr (head_next),
		.rd_data (head_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			bytes_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			head_q   <= head_next;
			tail_q   <= tail_next;
			cnt_q    <= cnt_next;
			bytes_q  <= bytes_next;
			valid_s2 <= valid_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2.accepted     <= do_push;
			rsp_s2.dropped      <= is_enq && refuse;
			rsp_s2.found        <= found;
			rsp_s2.head_handle  <= found ? head_entry.handle : '0;
			rsp_s2.head_size    <= found ? head_entry.size : '0;
			rsp_s2.packet_count <= 8'(cnt_next);
			rsp_s2.byte_count   <= bytes_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = rsp_s2;

endmodule
